### rtl/core/nnvl_pkg.sv
// Shared types, widths and command/status codes for the nearest-note layer selector.
`timescale 1ns / 1ps

package nnvl_pkg;

  // Table size and derived widths
  localparam int MaxEntries  = 1024;
  localparam int IdxW        = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW        = $clog2(MaxEntries + 1);
  localparam int EntryIndexW = 10;

  // Field widths
  localparam int CmdW    = 2;
  localparam int NoteW   = 7;
  localparam int VelW    = 7;
  localparam int StatusW = 2;

  // Command codes
  localparam logic [CmdW-1:0] CmdClear  = 2'd0;
  localparam logic [CmdW-1:0] CmdInsert = 2'd1;
  localparam logic [CmdW-1:0] CmdFind   = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] StatOk    = 2'd0;
  localparam logic [StatusW-1:0] StatEmpty = 2'd1;
  localparam logic [StatusW-1:0] StatFull  = 2'd2;

  // One stored table entry
  typedef struct packed {
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  vel_min;
    logic [VelW-1:0]  vel_max;
  } entry_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

### rtl/core/nnvl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module nnvl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // Write on enable; the read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/nearest_note_velocity_layer_select.sv
// Top level of the nearest-note, velocity-layer sample selector.
`timescale 1ns / 1ps

// Keeps a table of up to MaxEntries sample entries (note plus velocity range) in
// one RAM, indexed in load order. Clear, insert and unused commands, and a find
// on an empty table, go from idle straight to the done state, which loads their
// result into the output register; the next item is accepted once back in idle.
// A find walks the stored entries through the RAM read port, one entry per cycle,
// and keeps the best candidate so far: nearest note first (lower note on a tie),
// then the first entry of that note with the smallest velocity distance. Its
// result index is taken from the best candidate when the scan ends and then
// moves through the done state into the output register. One item is
// in work at a time; in_stall stays high from acceptance until the result has
// been moved into the output register, which then waits on out_stall on its own.
// A stalled output register adds its stall cycles to the item in work.
// Entries are never cleared in the RAM; only the fill count is reset.
module nearest_note_velocity_layer_select (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [nnvl_pkg::CmdW-1:0]          cmd,
  input  logic [nnvl_pkg::NoteW-1:0]         note,
  input  logic [nnvl_pkg::VelW-1:0]          range_low,
  input  logic [nnvl_pkg::VelW-1:0]          range_high,
  input  logic [nnvl_pkg::VelW-1:0]          velocity,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [nnvl_pkg::StatusW-1:0]       status,
  output logic [nnvl_pkg::EntryIndexW-1:0]   entry_index
);

  import nnvl_pkg::*;

  state_t state, state_next;

  logic [CntW-1:0]    count;
  logic [CntW-1:0]    scan_addr;
  logic               cmp_valid;
  logic [IdxW-1:0]    cmp_idx;

  logic [NoteW-1:0]   look_note;
  logic [VelW-1:0]    look_vel;

  logic               have;
  logic [NoteW-1:0]   best_note;
  logic [NoteW-1:0]   best_nd;
  logic [VelW-1:0]    best_vd;
  logic [IdxW-1:0]    best_idx;

  logic [StatusW-1:0] res_status;
  logic [IdxW-1:0]    res_index;

  logic               accept;
  logic               full;
  logic               ram_we;
  logic               issue;
  logic               scan_end;
  logic               out_load;
  entry_t             wr_entry;
  entry_t             rd_entry;

  logic [NoteW-1:0]   cand_nd;
  logic [VelW-1:0]    cand_vd;
  logic               take_note;
  logic               take_vel;

  // Handshake and table status
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign full     = (count >= CntW'(MaxEntries));
  assign ram_we   = accept && (cmd == CmdInsert) && !full;
  assign issue    = (state == ST_SCAN) && (scan_addr < count);
  assign scan_end = (state == ST_SCAN) && !issue && !cmp_valid;
  assign out_load = (state == ST_DONE) && (!out_valid || !out_stall);

  assign wr_entry.note    = note;
  assign wr_entry.vel_min = range_low;
  assign wr_entry.vel_max = range_high;

  nnvl_ram #(
    .Width ($bits(entry_t)),
    .Depth (MaxEntries)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IdxW-1:0]),
    .wdata (wr_entry),
    .raddr (scan_addr[IdxW-1:0]),
    .rdata (rd_entry)
  );

  // Note and velocity distances of the entry coming out of the RAM
  always_comb begin
    if (rd_entry.note >= look_note) begin
      cand_nd = rd_entry.note - look_note;
    end else begin
      cand_nd = look_note - rd_entry.note;
    end
    if (look_vel < rd_entry.vel_min) begin
      cand_vd = rd_entry.vel_min - look_vel;
    end else if (look_vel > rd_entry.vel_max) begin
      cand_vd = look_vel - rd_entry.vel_max;
    end else begin
      cand_vd = '0;
    end
    take_note = !have || (cand_nd < best_nd) ||
                ((cand_nd == best_nd) && (rd_entry.note < best_note));
    take_vel  = have && (rd_entry.note == best_note) && (cand_vd < best_vd);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((cmd == CmdFind) && (count != '0)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill count and scan pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= issue;
      if (accept && (cmd == CmdClear)) begin
        count <= '0;
      end else if (ram_we) begin
        count <= count + 1'b1;
      end
    end
  end

  // Scan address, lookup key, best candidate and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      look_note  <= note;
      look_vel   <= velocity;
      scan_addr  <= '0;
      have       <= 1'b0;
      case (cmd)
        CmdInsert: begin
          if (full) begin
            res_status <= StatFull;
            res_index  <= '0;
          end else begin
            res_status <= StatOk;
            res_index  <= count[IdxW-1:0];
          end
        end
        CmdFind: begin
          if (count == '0) begin
            res_status <= StatEmpty;
          end else begin
            res_status <= StatOk;
          end
          res_index <= '0;
        end
        default: begin
          res_status <= StatOk;
          res_index  <= '0;
        end
      endcase
    end
    if (issue) begin
      scan_addr <= scan_addr + 1'b1;
      cmp_idx   <= scan_addr[IdxW-1:0];
    end
    // Replace the candidate on a better note, or on a closer layer of the same note
    if (cmp_valid) begin
      if (take_note) begin
        have      <= 1'b1;
        best_note <= rd_entry.note;
        best_nd   <= cand_nd;
        best_vd   <= cand_vd;
        best_idx  <= cmp_idx;
      end else if (take_vel) begin
        best_vd  <= cand_vd;
        best_idx <= cmp_idx;
      end
    end
    if (scan_end) begin
      res_index <= best_idx;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      entry_index <= EntryIndexW'(res_index);
    end
  end

  // Fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxEntries))
    else $error("entry count above table size");

  // An accepted insert into a non-full table grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (count == $past(count) + 1'b1))
    else $error("insert did not advance entry count");

  // Every compared entry lies below the fill count
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (CntW'(cmp_idx) < count))
    else $error("scan compared an entry beyond the fill count");

  // A finished result waits while the output register is full and stalled
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && out_stall) |=> (state == ST_DONE))
    else $error("result left done state while output was blocked");

  // A find that ends its scan has found at least one candidate
  a_scan_found: assert property (@(posedge clk) disable iff (rst)
    scan_end |-> have)
    else $error("scan ended without a candidate");

endmodule
